// ===== src/rsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types and constants of the regular space clustering block.
// ----------------------------------------------------------------------------
package rsc_pkg;

   localparam int COORD_W = 16;
   localparam int DIST_W = 40;
   localparam int STATUS_W = 2;
   localparam int INDEX_W = 6;
   localparam int COUNT_W = 7;
   localparam int DIM_W = 5;

   localparam logic [STATUS_W-1:0] STATUS_NEAR = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NEW = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LIMIT = 2'd2;

   localparam logic [1:0] CSR_CUTOFF = 2'd0;
   localparam logic [1:0] CSR_LIMIT = 2'd1;
   localparam logic [1:0] CSR_DIM = 2'd2;

   typedef struct packed {
      logic start;      // Latch a beat and begin a sweep.
      logic step;       // Process the current center.
      logic finish;     // Close the beat (store coordinate, maybe end frame).
      logic find_min;   // Minimum search step.
      logic close_frame;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic sweep_done;
      logic min_done;
      logic frame_end;
   } sts_type;

endpackage

// ===== src/regular_space_clustering.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// regular_space_clustering
// Leader clustering over fixed-point frames with a squared Euclidean distance.
// ----------------------------------------------------------------------------
// Frame coordinates enter one beat at a time on req_*, dim_in_use per frame.
// Each beat sweeps the stored centers, one center per cycle from the center
// memory, through the read, square and accumulate pipeline. After the last
// beat of a frame a second pass over the accumulators finds the minimum and
// closes the frame, then one result beat with status, center index, minimum
// distance and center count is offered on rsp_*. The block waits until that
// beat is taken before it accepts the next coordinate. Registers must be
// written on the csr_* port only while the block is idle; the block itself
// does not enforce this. Reset clears the center count, the frame position
// and the limit error; center memory contents are not cleared.
// ----------------------------------------------------------------------------
module regular_space_clustering #(
   parameter int MAX_CENTERS = 64,
   parameter int MAX_DIM = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [15:0] req_tdata,  // coordinate[15:0]
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [55:0] rsp_tdata,  // status, center_index, min_dist_sq, center_count, pad
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [39:0] csr_wdata
);
   import rsc_pkg::*;

   logic [DIST_W-1:0] cutoff_ff;
   logic [COUNT_W-1:0] limit_ff;
   logic [DIM_W-1:0] dim_ff;
   cmd_type cmd;
   sts_type sts;
   logic [STATUS_W-1:0] status;
   logic [INDEX_W-1:0] center_index;
   logic [DIST_W-1:0] min_dist_sq;
   logic [COUNT_W-1:0] center_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= '0;
         limit_ff <= COUNT_W'(64);
         dim_ff <= DIM_W'(16);
      end else if (csr_we) begin
         case (csr_index)
            CSR_CUTOFF: cutoff_ff <= csr_wdata;
            CSR_LIMIT: limit_ff <= csr_wdata[COUNT_W-1:0];
            CSR_DIM: dim_ff <= csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   rsc_controller u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .cmd(cmd), .sts(sts)
   );

   rsc_datapath #(.MAX_CENTERS(MAX_CENTERS), .MAX_DIM(MAX_DIM)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .coord(req_tdata), .cutoff_sq(cutoff_ff), .center_limit(limit_ff),
      .dim_in_use(dim_ff), .status(status), .center_index(center_index),
      .min_dist_sq(min_dist_sq), .center_count(center_count)
   );

   assign rsp_tdata = {1'b0, center_count, min_dist_sq, center_index, status};

endmodule

// ===== src/rsc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_datapath
// Center memory, accumulator memory, distance unit and frame bookkeeping.
// ----------------------------------------------------------------------------
module rsc_datapath #(
   parameter int MAX_CENTERS = 64,
   parameter int MAX_DIM = 16,
   parameter int CW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1,
   parameter int PW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
   input  logic clock,
   input  logic reset,
   input  rsc_pkg::cmd_type cmd,
   output rsc_pkg::sts_type sts,
   input  logic [rsc_pkg::COORD_W-1:0] coord,
   input  logic [rsc_pkg::DIST_W-1:0] cutoff_sq,
   input  logic [rsc_pkg::COUNT_W-1:0] center_limit,
   input  logic [rsc_pkg::DIM_W-1:0] dim_in_use,
   output logic [rsc_pkg::STATUS_W-1:0] status,
   output logic [rsc_pkg::INDEX_W-1:0] center_index,
   output logic [rsc_pkg::DIST_W-1:0] min_dist_sq,
   output logic [rsc_pkg::COUNT_W-1:0] center_count
);
   import rsc_pkg::*;

   localparam int NW = $clog2(MAX_CENTERS + 1);
   localparam int LW = (NW > COUNT_W) ? NW : COUNT_W;
   localparam int DW = (PW + 1 > DIM_W) ? PW + 1 : DIM_W;
   localparam int AW = (MAX_CENTERS * MAX_DIM > 1) ? $clog2(MAX_CENTERS * MAX_DIM) : 1;
   localparam logic [DIST_W-1:0] ALL_ONES = {DIST_W{1'b1}};

   logic [COORD_W-1:0] center_mem [MAX_CENTERS*MAX_DIM];
   logic [DIST_W-1:0] acc_mem [MAX_CENTERS];

   logic signed [COORD_W-1:0] x_ff;
   logic [NW-1:0] stored_ff, stored_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic first_ff, first_in;
   logic error_ff, error_in;
   logic [CW:0] k_ff, k_in;
   logic [CW:0] rk_ff;
   logic rd_valid_ff;
   logic signed [COORD_W-1:0] cen_ff;
   logic [DIST_W-1:0] acc_rd_ff;
   logic [2*COORD_W-1:0] sq_ff;
   logic [CW-1:0] wk_ff;
   logic sq_valid_ff;
   logic [DIST_W-1:0] acc_old_ff;
   logic [DIST_W-1:0] min_ff, min_in;
   logic [STATUS_W-1:0] status_ff;
   logic [INDEX_W-1:0] index_ff;

   logic [DW-1:0] dim_eff;
   logic [LW-1:0] lim_eff;
   logic [PW-1:0] pos_eff;
   logic signed [COORD_W:0] diff;
   logic [COORD_W:0] mag;
   logic [DIST_W:0] sum;
   logic [LW-1:0] stored_ext;
   logic issue;

   always_comb begin
      if (dim_in_use == '0) begin
         dim_eff = DW'(1);
      end else if (DW'(dim_in_use) > DW'(MAX_DIM)) begin
         dim_eff = DW'(MAX_DIM);
      end else begin
         dim_eff = DW'(dim_in_use);
      end
      if (LW'(center_limit) > LW'(MAX_CENTERS)) begin
         lim_eff = LW'(MAX_CENTERS);
      end else begin
         lim_eff = LW'(center_limit);
      end
      stored_ext = LW'(stored_ff);
      pos_eff = pos_ff;
      diff = $signed({x_ff[COORD_W-1], x_ff}) - $signed({cen_ff[COORD_W-1], cen_ff});
      mag = diff[COORD_W] ? (COORD_W+1)'(0) - diff : diff;
      sum = {1'b0, acc_old_ff} + (DIST_W+1)'(sq_ff);
   end

   // Sweep: issue reads for center k, one per cycle; pipeline squares and writes back.
   assign issue = cmd.step && (k_ff < (CW+1)'(stored_ff));
   assign k_in = (cmd.start || cmd.finish) ? '0 : (issue || cmd.find_min) ? k_ff + 1'b1 : k_ff;

   always_comb begin
      sts.sweep_done = (k_ff >= (CW+1)'(stored_ff)) && !rd_valid_ff && !sq_valid_ff;
      sts.min_done = k_ff > (CW+1)'(stored_ff);
      sts.frame_end = (DW'(pos_ff) + 1'b1) >= dim_eff;
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         x_ff <= coord;
      end
      rk_ff <= k_ff;
      cen_ff <= center_mem[AW'(k_ff[CW-1:0]) * AW'(MAX_DIM) + AW'(pos_eff)];
      acc_rd_ff <= acc_mem[k_ff[CW-1:0]];
      sq_ff <= (2*COORD_W)'(mag) * (2*COORD_W)'(mag);
      acc_old_ff <= first_ff ? '0 : acc_rd_ff;
      wk_ff <= rk_ff[CW-1:0];
      if (sq_valid_ff) begin
         acc_mem[wk_ff] <= sum[DIST_W] ? ALL_ONES : sum[DIST_W-1:0];
      end
      if (cmd.finish && stored_ff < NW'(MAX_CENTERS)) begin
         center_mem[AW'(stored_ff[CW-1:0]) * AW'(MAX_DIM) + AW'(pos_eff)] <= x_ff;
      end
   end

   // Two-stage pipeline valid flags (read, then square).
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         sq_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= issue;
         sq_valid_ff <= rd_valid_ff;
      end
   end

   always_comb begin
      min_in = min_ff;
      if (cmd.start) begin
         min_in = ALL_ONES;
      end else if (cmd.find_min && (rk_ff < (CW+1)'(stored_ff))) begin
         if (acc_rd_ff < min_ff) begin
            min_in = acc_rd_ff;
         end
      end
   end

   always_comb begin
      stored_in = stored_ff;
      error_in = error_ff;
      pos_in = pos_ff;
      first_in = first_ff;
      if (cmd.finish) begin
         if (sts.frame_end) begin
            pos_in = '0;
            first_in = 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
            first_in = 1'b0;
         end
      end
      if (cmd.close_frame && !error_ff && min_ff > cutoff_sq) begin
         if (stored_ext + 1'b1 > lim_eff) begin
            error_in = 1'b1;
         end else begin
            stored_in = stored_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_ff <= '0;
         error_ff <= 1'b0;
         pos_ff <= '0;
         first_ff <= 1'b1;
         k_ff <= '0;
         min_ff <= ALL_ONES;
      end else begin
         stored_ff <= stored_in;
         error_ff <= error_in;
         pos_ff <= pos_in;
         first_ff <= first_in;
         k_ff <= k_in;
         min_ff <= min_in;
      end
      if (cmd.close_frame) begin
         if (error_in) begin
            status_ff <= STATUS_LIMIT;
            index_ff <= '0;
         end else if (stored_in != stored_ff) begin
            status_ff <= STATUS_NEW;
            index_ff <= INDEX_W'(stored_ff);
         end else begin
            status_ff <= STATUS_NEAR;
            index_ff <= '0;
         end
      end
   end

   assign status = status_ff;
   assign center_index = index_ff;
   assign min_dist_sq = min_ff;
   assign center_count = COUNT_W'(stored_ff);

endmodule

// ===== src/rsc_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_controller
// Sequencer for the per-beat sweep, minimum search and result handshake.
// ----------------------------------------------------------------------------
module rsc_controller (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output rsc_pkg::cmd_type cmd,
   input  rsc_pkg::sts_type sts
);
   import rsc_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SWEEP = 6'b000010,
      S_DRAIN = 6'b000100,
      S_MIN   = 6'b001000,
      S_CLOSE = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic k_start_ff;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in = S_SWEEP;
            end
         end
         S_SWEEP: begin
            if (sts.sweep_done) begin
               cmd.finish = 1'b1;
               if (sts.frame_end) begin
                  cmd.start = 1'b0;
                  state_in = S_DRAIN;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               cmd.step = !k_start_ff;
            end
         end
         S_DRAIN: begin
            state_in = S_MIN;
         end
         S_MIN: begin
            if (sts.min_done) begin
               state_in = S_CLOSE;
            end else begin
               cmd.find_min = 1'b1;
            end
         end
         S_CLOSE: begin
            cmd.close_frame = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_start_ff <= 1'b0;
      end
   end

endmodule
